// ===== hw/rtl/mandelbrot_escape_count_assert.svh =====
// assertion macros for the mandelbrot escape counter
`ifndef MANDELBROT_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mec_pkg.sv =====
// types and constants shared by the mandelbrot escape counter
`default_nettype none
package mec_pkg;

	localparam int FRAC_W = 16;
	localparam int CFG_W = 19;
	localparam int CNT_W = 10;
	localparam int ROW_W = 5;
	localparam int COL_W = 7;
	localparam int CFG_IDX_W = 3;
	// span times index, widest case
	localparam int PROD_W = CFG_W + COL_W;
	// z and c, wide enough for any mapped point plus one step
	localparam int Z_W = PROD_W + 2;
	// square shifted down by the fraction
	localparam int SQ_W = 2 * Z_W - FRAC_W;

	localparam logic [SQ_W:0] ESC_BOUND = (SQ_W + 1)'(4) << FRAC_W;

	localparam logic [CFG_W-1:0] RST_REAL_ORIGIN = CFG_W'(-164659);
	localparam logic [CFG_W-1:0] RST_REAL_SPAN = CFG_W'(229376);
	localparam logic [CFG_W-1:0] RST_IMAG_ORIGIN = CFG_W'(-75366);
	localparam logic [CFG_W-1:0] RST_IMAG_SPAN = CFG_W'(150733);
	localparam logic [CNT_W-1:0] RST_ITER_LIMIT = CNT_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REAL_ORIGIN = 3'd0,
		CFG_REAL_SPAN = 3'd1,
		CFG_IMAG_ORIGIN = 3'd2,
		CFG_IMAG_SPAN = 3'd3,
		CFG_ITER_LIMIT = 3'd4
	} mec_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ITER
	} mec_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mec_serdiv.sv =====
// divider by a constant through reciprocal multiplication: dividend registered at start, then quotient
`default_nettype none
module mec_serdiv #(
	parameter int NW = 26,
	parameter int DIVISOR = 69
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	output logic               busy,
	output logic [NW-1:0]      quotient
);

	// floor(x / DIVISOR) equals floor(x * RECIP / 2^SHIFT) for every NW-bit x
	localparam int LW = $clog2(DIVISOR);
	localparam int SHIFT = NW + LW;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [NW:0] RECIP = RECIP_FULL[NW:0];
	localparam int PW = SHIFT + NW;

	logic          pend_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quot_q;
	logic [PW-1:0] prod;

	assign prod = PW'(num_q) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end
		if (pend_q) begin
			quot_q <= prod[SHIFT +: NW];
		end
	end

	assign busy = pend_q;
	assign quotient = quot_q;

endmodule
`default_nettype wire

// ===== hw/rtl/mec_zstep.sv =====
// one step of z = z^2 + c with the escape test on the squares
`default_nettype none
module mec_zstep import mec_pkg::*; (
	input  wire logic signed [Z_W-1:0] zr,
	input  wire logic signed [Z_W-1:0] zi,
	input  wire logic [Z_W-1:0]        cr,
	input  wire logic [Z_W-1:0]        ci,
	output logic [Z_W-1:0]             zr_next,
	output logic [Z_W-1:0]             zi_next,
	output logic                       escaped
);

	logic signed [2*Z_W-1:0] rr;
	logic signed [2*Z_W-1:0] ii;
	logic signed [2*Z_W-1:0] ri;
	logic [SQ_W-1:0]         re2;
	logic [SQ_W-1:0]         im2;
	logic [SQ_W:0]           mag2;

	always_comb begin
		rr = (2*Z_W)'(zr) * (2*Z_W)'(zr);
		ii = (2*Z_W)'(zi) * (2*Z_W)'(zi);
		ri = (2*Z_W)'(zr) * (2*Z_W)'(zi);
		// squares are never negative, so dropping the fraction floors them
		re2 = rr[2*Z_W-1:FRAC_W];
		im2 = ii[2*Z_W-1:FRAC_W];
		mag2 = {1'b0, re2} + {1'b0, im2};
		escaped = (mag2 > ESC_BOUND);
		zr_next = re2[Z_W-1:0] - im2[Z_W-1:0] + cr;
		// doubling then flooring by the fraction is a floor by one bit less
		zi_next = ri[FRAC_W-1 +: Z_W] + ci;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_count.sv =====
// top level of the mandelbrot escape counter
//
// An item (pixel_row, pixel_col) is taken on the input channel when in_valid is high and
// in_stall is low. The pixel is mapped to a point c of the window held in the config
// registers, then z = z^2 + c is iterated from zero until |z|^2 exceeds 4.0 or the count
// reaches iteration_limit; that count comes back as one item on the output channel.
// The span products are registered at accept, the two dividers by the grid size minus one
// multiply them by a reciprocal in the next cycle, and then c is loaded; the complex square
// unit does one iteration per cycle until the loop ends. A new item can be taken in the
// cycle after the result is loaded. in_stall is high while an item is being worked on.
// The result sits in an output register; if out_stall holds it there when the next item
// finishes, that item waits in its last iteration state until the register frees up.
// Reset clears the channels and loads the default window and limit. Config writes are
// taken at any clk edge with cfg_we high and are meant for when the block is idle.
`default_nettype none
module mandelbrot_escape_count import mec_pkg::*; #(
	parameter int GRID_WIDTH = 70,
	parameter int GRID_HEIGHT = 22
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ROW_W-1:0]     pixel_row,
	input  wire logic [COL_W-1:0]     pixel_col,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CNT_W-1:0]          escape_count
);

	logic [CFG_W-1:0] real_origin_q;
	logic [CFG_W-1:0] real_span_q;
	logic [CFG_W-1:0] imag_origin_q;
	logic [CFG_W-1:0] imag_span_q;
	logic [CNT_W-1:0] iter_limit_q;

	mec_state_t state_q, state_d;
	logic div_start, load_c, step, load_out;

	logic [PROD_W-1:0] re_dividend, im_dividend;
	logic [PROD_W-1:0] re_quot, im_quot;
	logic              re_busy, im_busy, div_busy;

	logic [Z_W-1:0] cr_q, ci_q;
	logic [Z_W-1:0] zr_q, zi_q;
	logic [Z_W-1:0] zr_next, zi_next;
	logic           escaped;
	logic [CNT_W-1:0] n_q;
	logic           stop;
	logic           out_valid_q;
	logic [CNT_W-1:0] escape_count_q;
	logic           out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= RST_REAL_ORIGIN;
			real_span_q <= RST_REAL_SPAN;
			imag_origin_q <= RST_IMAG_ORIGIN;
			imag_span_q <= RST_IMAG_SPAN;
			iter_limit_q <= RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REAL_ORIGIN: real_origin_q <= cfg_data;
				CFG_REAL_SPAN: real_span_q <= cfg_data;
				CFG_IMAG_ORIGIN: imag_origin_q <= cfg_data;
				CFG_IMAG_SPAN: imag_span_q <= cfg_data;
				CFG_ITER_LIMIT: iter_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pixel to point mapping
	assign re_dividend = PROD_W'(real_span_q) * PROD_W'(pixel_col);
	assign im_dividend = PROD_W'(imag_span_q) * PROD_W'(pixel_row);

	mec_serdiv #(
		.NW(PROD_W),
		.DIVISOR(GRID_WIDTH - 1)
	) u_div_re (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(re_dividend),
		.busy(re_busy),
		.quotient(re_quot)
	);

	mec_serdiv #(
		.NW(PROD_W),
		.DIVISOR(GRID_HEIGHT - 1)
	) u_div_im (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(im_dividend),
		.busy(im_busy),
		.quotient(im_quot)
	);

	assign div_busy = re_busy | im_busy;

	mec_zstep u_zstep (
		.zr(signed'(zr_q)),
		.zi(signed'(zi_q)),
		.cr(cr_q),
		.ci(ci_q),
		.zr_next(zr_next),
		.zi_next(zi_next),
		.escaped(escaped)
	);

	assign stop = escaped || (n_q >= iter_limit_q);
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		load_c = 1'b0;
		step = 1'b0;
		load_out = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					load_c = 1'b1;
					state_d = ST_ITER;
				end
			end
			ST_ITER: begin
				if (!stop) begin
					step = 1'b1;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// iteration datapath
	always_ff @(posedge clk) begin
		if (load_c) begin
			cr_q <= {{(Z_W - CFG_W){real_origin_q[CFG_W-1]}}, real_origin_q}
				+ {{(Z_W - PROD_W){1'b0}}, re_quot};
			ci_q <= {{(Z_W - CFG_W){imag_origin_q[CFG_W-1]}}, imag_origin_q}
				+ {{(Z_W - PROD_W){1'b0}}, im_quot};
			zr_q <= '0;
			zi_q <= '0;
		end else if (step) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (load_c) begin
			n_q <= '0;
		end else if (step) begin
			n_q <= n_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			escape_count_q <= n_q;
		end
	end

	assign out_valid = out_valid_q;
	assign escape_count = escape_count_q;

`include "mandelbrot_escape_count_assert.svh"

	`MEC_ASSERT_NOW(a_count_in_limit, state_q == ST_ITER, n_q <= iter_limit_q,
		"iteration count passed the limit")
	`MEC_ASSERT_NOW(a_result_in_limit, out_valid_q, escape_count_q <= iter_limit_q,
		"result above the iteration limit")
	`MEC_ASSERT_NEXT(a_accept_starts_map, in_valid && !in_stall,
		state_q == ST_DIV && div_busy, "accepted item did not start the mapping")
	`MEC_ASSERT_NEXT(a_finish_loads_out, load_out,
		state_q == ST_IDLE && out_valid_q, "finished item did not reach the output")

endmodule
`default_nettype wire

// ===== tb/sv/mandelbrot_escape_count_test.sv =====
// self-checking testbench for the mandelbrot escape counter: directed and random pixels
module mandelbrot_escape_count_test import mec_pkg::*; ();

	localparam int GRID_W = 70;
	localparam int GRID_H = 22;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 500;
	localparam int END_WAIT = 1100;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ROW_W-1:0] pixel_row = '0;
	logic [COL_W-1:0] pixel_col = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_W-1:0] escape_count;

	// window and limit as the block should hold them
	logic [CFG_W-1:0] win_re_org;
	logic [CFG_W-1:0] win_re_span;
	logic [CFG_W-1:0] win_im_org;
	logic [CFG_W-1:0] win_im_span;
	logic [CNT_W-1:0] win_limit;

	pixel_t pending_pixels[$];
	logic [CNT_W-1:0] expected_counts[$];
	logic [CNT_W-1:0] want_count;
	int fail_cnt = 0;
	int results_seen = 0;
	int cycle_cnt = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int last_hold_at = -1;
	int pat_mode = 0;
	int pat_left = 0;

	mandelbrot_escape_count #(
		.GRID_WIDTH(GRID_W),
		.GRID_HEIGHT(GRID_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_row(pixel_row),
		.pixel_col(pixel_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.escape_count(escape_count)
	);

	always #2 clk = ~clk;

	function automatic logic [CNT_W-1:0] escape_iters(logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col);
		longint cr, ci, zr, zi, re2, im2, nr, bound;
		int n;
		bound = longint'(4) << FRAC_W;
		cr = longint'($signed(win_re_org)) + (longint'(win_re_span) * longint'(col)) / (GRID_W - 1);
		ci = longint'($signed(win_im_org)) + (longint'(win_im_span) * longint'(row)) / (GRID_H - 1);
		zr = 0;
		zi = 0;
		n = 0;
		re2 = 0;
		im2 = 0;
		while (re2 + im2 <= bound && n < int'(win_limit)) begin
			nr = re2 - im2 + cr;
			zi = ((2 * zr * zi) >>> FRAC_W) + ci;
			zr = nr;
			n++;
			re2 = (zr * zr) >>> FRAC_W;
			im2 = (zi * zi) >>> FRAC_W;
		end
		return CNT_W'(n);
	endfunction

	task automatic note_failure(input string what, input int want, input int got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_REAL_ORIGIN: win_re_org = data;
			CFG_REAL_SPAN: win_re_span = data;
			CFG_IMAG_ORIGIN: win_im_org = data;
			CFG_IMAG_SPAN: win_im_span = data;
			CFG_ITER_LIMIT: win_limit = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input int re_org, input int re_span, input int im_org,
			input int im_span, input logic [CFG_W-1:0] limit_data);
		write_reg(CFG_REAL_ORIGIN, CFG_W'(re_org));
		write_reg(CFG_REAL_SPAN, CFG_W'(re_span));
		write_reg(CFG_IMAG_ORIGIN, CFG_W'(im_org));
		write_reg(CFG_IMAG_SPAN, CFG_W'(im_span));
		write_reg(CFG_ITER_LIMIT, limit_data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_pixel(input int row, input int col);
		pixel_t p;
		p.row = ROW_W'(row);
		p.col = COL_W'(col);
		pending_pixels.push_back(p);
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || expected_counts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// sender: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_row <= '0;
			pixel_col <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_counts.push_back(escape_iters(pixel_row, pixel_col));
				void'(pending_pixels.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
				end
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					in_valid <= 1'b1;
					pixel_row <= pending_pixels[0].row;
					pixel_col <= pending_pixels[0].col;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each item, stall on its own pattern with two long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_counts.size() == 0) begin
					note_failure("unexpected item", -1, int'(escape_count));
				end else begin
					want_count = expected_counts.pop_front();
					if (want_count !== escape_count)
						note_failure("escape_count mismatch", int'(want_count),
							int'(escape_count));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if ((results_seen == 300 || results_seen == 1200)
					&& results_seen != last_hold_at) begin
				last_hold_at = results_seen;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 2);
					pat_left = $urandom_range(20, 400);
				end else begin
					pat_left--;
				end
				case (pat_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("mandelbrot_escape_count_test: FAIL");
			$finish;
		end
	end

	initial begin
		int cx, cy, sz, lim, n_items;
		logic [CFG_W-1:0] lim_data;
		win_re_org = RST_REAL_ORIGIN;
		win_re_span = RST_REAL_SPAN;
		win_im_org = RST_IMAG_ORIGIN;
		win_im_span = RST_IMAG_SPAN;
		win_limit = RST_ITER_LIMIT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// default window: corners, center, indexes beyond the grid
		add_pixel(0, 0);
		add_pixel(21, 69);
		add_pixel(0, 69);
		add_pixel(21, 0);
		add_pixel(11, 35);
		add_pixel(31, 127);
		add_pixel(31, 0);
		add_pixel(0, 127);
		add_pixel(10, 20);
		drain();

		// zero limit through high data bits, writes to unused indexes
		write_reg(CFG_ITER_LIMIT, 19'h7FC00);
		for (int i = CFG_IDX_SPARE_FIRST; i <= CFG_IDX_SPARE_LAST; i++)
			write_reg(CFG_IDX_W'(i), '1);
		@(posedge clk);
		cfg_we <= 1'b0;
		add_pixel(11, 35);
		add_pixel(31, 127);
		add_pixel(0, 0);
		drain();

		// register extremes
		set_window(-262144, 524287, 262143, 0, 19'h003FF);
		add_pixel(0, 0);
		add_pixel(21, 69);
		add_pixel(31, 127);
		drain();
		set_window(262143, 0, -262144, 524287, 19'h00001);
		add_pixel(0, 0);
		add_pixel(31, 127);
		add_pixel(5, 60);
		drain();

		// c = -2 sits exactly on the escape bound, c = 0 and c just below -1 never escape
		set_window(-131072, 131072, 0, 0, 19'h003FF);
		add_pixel(0, 0);
		add_pixel(0, 69);
		add_pixel(0, 34);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 3)
				lim = 1;
			else if (ph == 6)
				lim = 1023;
			else
				lim = $urandom_range(2, 255);
			lim_data = (CFG_W'($urandom) & 19'h7FC00) | CFG_W'(lim);
			if ($urandom_range(0, 3) == 0) begin
				set_window($urandom, $urandom, $urandom, $urandom, lim_data);
			end else begin
				cx = $urandom_range(0, 170000) - 140000;
				cy = $urandom_range(0, 140000) - 70000;
				sz = $urandom_range(1000, 200000);
				set_window(cx - sz / 2, sz, cy - sz * 3 / 10, sz * 3 / 5, lim_data);
			end
			n_items = (ph == 6) ? 30 : 180;
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(0, 6) == 0)
					add_pixel($urandom_range(0, 31), $urandom_range(0, 127));
				else
					add_pixel($urandom_range(0, GRID_H - 1), $urandom_range(0, GRID_W - 1));
			end
			drain();
		end

		repeat (END_WAIT) @(posedge clk);
		if (fail_cnt == 0 && expected_counts.size() == 0)
			$display("mandelbrot_escape_count_test: PASS");
		else
			$display("mandelbrot_escape_count_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mec_pkg.sv
hw/rtl/mec_serdiv.sv
hw/rtl/mec_zstep.sv
hw/rtl/mandelbrot_escape_count.sv
tb/sv/mandelbrot_escape_count_test.sv
